>>> design/iqac_pkg.sv
// ---------------------------------------------------------------------------
// iqac_pkg
// Shared types and constants of the IQ-to-audio channeliser.
// ---------------------------------------------------------------------------
package iqac_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CSTEP_W      = 4;
	localparam int STAGE_W      = 24;
	localparam int SUM_W        = 38;
	localparam int COUNT_W      = 14;
	localparam int RATE_W       = 27;
	localparam int COEF_W       = 18;
	localparam int ACC_W        = 34;   // CORDIC datapath, Q.30 plus guard
	localparam logic signed [ACC_W-1:0] KGAIN_Q30 = 34'sd652032874;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd16383;

	// configuration register indexes
	localparam logic [2:0] REG_TUNE_STEP = 3'd0;
	localparam logic [2:0] REG_TONE_STEP = 3'd1;
	localparam logic [2:0] REG_COEF      = 3'd2;
	localparam logic [2:0] REG_IN_RATE   = 3'd3;
	localparam logic [2:0] REG_OUT_RATE  = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OSC,       // tuning CORDIC
		ST_MIX,       // complex mix
		ST_FILT_R,    // stage k real
		ST_FILT_I,    // stage k imag
		ST_ACC,       // sum, rate phase
		ST_DIV,       // average division
		ST_TONE,      // tone CORDIC
		ST_AUDIO,     // final mix
		ST_OUT
	} state_t;

	// CORDIC angle table in turns scaled by 2^32
	function automatic logic signed [ACC_W-1:0] atan_turn(input logic [CSTEP_W-1:0] k);
		logic signed [ACC_W-1:0] r;
		case (k)
			4'd0:  r = 34'sd536870912;
			4'd1:  r = 34'sd316933406;
			4'd2:  r = 34'sd167458907;
			4'd3:  r = 34'sd85004756;
			4'd4:  r = 34'sd42667331;
			4'd5:  r = 34'sd21354465;
			4'd6:  r = 34'sd10679838;
			4'd7:  r = 34'sd5340245;
			4'd8:  r = 34'sd2670163;
			4'd9:  r = 34'sd1335087;
			4'd10: r = 34'sd667544;
			4'd11: r = 34'sd333772;
			4'd12: r = 34'sd166886;
			4'd13: r = 34'sd83443;
			4'd14: r = 34'sd41722;
			default: r = 34'sd20861;
		endcase
		return r;
	endfunction

	// round half up by 15 and saturate to 16 bits
	function automatic logic signed [15:0] osc_round(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + 34'sd16384) >>> 15;
		if (t > 34'sd32767) return 16'sd32767;
		if (t < -34'sd32768) return -16'sd32768;
		return t[15:0];
	endfunction

endpackage

>>> design/iqac_cordic.sv
// ---------------------------------------------------------------------------
// iqac_cordic
// Iterative rotation CORDIC: one micro-rotation per cycle, cosine and sine
// of a phase word rounded to Q1.15.
// ---------------------------------------------------------------------------
module iqac_cordic #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [PHASE_WIDTH-1:0] phase,
	output logic                   done,
	output logic signed [15:0]     cos_o,
	output logic signed [15:0]     sin_o
);
	logic signed [iqac_pkg::ACC_W-1:0] x_q, y_q, z_q;
	logic signed [iqac_pkg::ACC_W-1:0] z0, xs, ys, x_fin, y_fin;
	logic [31:0] a32;
	logic [iqac_pkg::CSTEP_W-1:0] k_q;
	logic busy_q, neg_q, done_q;

	// phase to signed turns; folded into the right half-plane when loaded on start
	always_comb begin
		a32 = 32'(phase) << (32 - PHASE_WIDTH);
		z0  = iqac_pkg::ACC_W'(signed'(a32));
	end

	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;

	// one micro-rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == iqac_pkg::CSTEP_W'(iqac_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= iqac_pkg::KGAIN_Q30;
			y_q <= '0;
			if (z0 > 34'sh40000000) begin
				z_q <= z0 - 34'sh80000000; neg_q <= 1'b1;
			end else if (z0 < -34'sh40000000) begin
				z_q <= z0 + 34'sh80000000; neg_q <= 1'b1;
			end else begin
				z_q <= z0; neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - iqac_pkg::atan_turn(k_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + iqac_pkg::atan_turn(k_q);
			end
		end
	end

	assign x_fin = neg_q ? -x_q : x_q;
	assign y_fin = neg_q ? -y_q : y_q;
	assign cos_o = iqac_pkg::osc_round(x_fin);
	assign sin_o = iqac_pkg::osc_round(y_fin);
	assign done  = done_q;
endmodule

>>> design/iqac_divider.sv
// ---------------------------------------------------------------------------
// iqac_divider
// Restoring divider, one quotient bit per cycle: signed 38-bit sum by a
// 14-bit count, truncated toward zero.
// ---------------------------------------------------------------------------
module iqac_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [iqac_pkg::SUM_W-1:0]   dividend,
	input  logic [iqac_pkg::COUNT_W-1:0]        divisor,
	output logic                                done,
	output logic signed [iqac_pkg::SUM_W-1:0]   quotient
);
	localparam int N = iqac_pkg::SUM_W;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0] q_q;
	logic [iqac_pkg::COUNT_W:0] r_q, trial;
	logic [iqac_pkg::COUNT_W-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, neg_q;

	assign trial = {r_q[iqac_pkg::COUNT_W-1:0], q_q[N-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one dividend bit, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[N-1];
			q_q   <= dividend[N-1] ? N'(-dividend) : N'(dividend);
			r_q   <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -signed'(q_q) : signed'(q_q);
	assign done = done_q;
endmodule

>>> design/iq_to_audio_channelizer.sv
// ---------------------------------------------------------------------------
// iq_to_audio_channelizer
// Tune, low-pass, fractionally decimate and tone-mix an IQ stream to audio.
// ---------------------------------------------------------------------------
// One IQ word is taken at a time. After the idle state takes a word, it
// passes through the iterative tuning CORDIC, the complex mix, each filter
// stage (real part, then imaginary part) and the decimator before the input
// opens again. When an audio word falls due, two bit-serial averaging
// divisions, the tone CORDIC, the tone mix and the hand-over follow, the
// hand-over waiting while out_stall is high. One shared multiplier serves
// mixing, every filter stage and the tone mix. in_stall is high while a word
// is in work; an audio word that waits on out_stall holds the block until
// taken.
module iq_to_audio_channelizer #(
	parameter int FILTER_STAGES = 4,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int PHASE_WIDTH   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
	input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] audio_sample
);
	localparam int SW = iqac_pkg::STAGE_W;
	localparam int KW = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;
	localparam int MIX_SH = SAMPLE_WIDTH - 8;
	localparam int AUD_SH = iqac_pkg::SUM_W - SAMPLE_WIDTH;
	localparam int PW = 56;   // product width

	// configuration registers
	logic [31:0] tune_step_q;
	logic [30:0] tone_step_q;
	logic [iqac_pkg::COEF_W-1:0] coef_q;
	logic [25:0] in_rate_q;
	logic [17:0] out_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_step_q <= '0;
			tone_step_q <= '0;
			coef_q      <= 18'd131072;
			in_rate_q   <= 26'd48000;
			out_rate_q  <= 18'd8000;
		end else if (cfg_we) begin
			case (cfg_index)
				iqac_pkg::REG_TUNE_STEP: tune_step_q <= cfg_data;
				iqac_pkg::REG_TONE_STEP: tone_step_q <= cfg_data[30:0];
				iqac_pkg::REG_COEF:      coef_q      <= cfg_data[17:0];
				iqac_pkg::REG_IN_RATE:   in_rate_q   <= cfg_data[25:0];
				iqac_pkg::REG_OUT_RATE:  out_rate_q  <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	iqac_pkg::state_t state_q, state_d;

	// signal state
	logic [PHASE_WIDTH-1:0] tune_ph_q, tone_ph_q;
	logic signed [SW-1:0] st_re_q [FILTER_STAGES];
	logic signed [SW-1:0] st_im_q [FILTER_STAGES];
	logic signed [iqac_pkg::SUM_W-1:0] sum_re_q, sum_im_q, avr_q, avi_q;
	logic [iqac_pkg::COUNT_W-1:0] cnt_q;
	logic [iqac_pkg::RATE_W-1:0] rate_q;
	logic signed [SAMPLE_WIDTH-1:0] xi_q, xq_q, audio_q;
	logic signed [SW-1:0] mr_q, mi_q;
	logic signed [15:0] c_q, s_q;
	logic [KW-1:0] k_q;
	logic [1:0] sub_q;      // mix / division / tone-mix sub-step
	logic out_q;

	// CORDIC and divider
	logic cs_start, c_done, d_start, d_done, div_im_q;
	logic [PHASE_WIDTH-1:0] c_phase;
	logic signed [15:0] c_cos, c_sin;
	logic signed [iqac_pkg::SUM_W-1:0] d_quot;

	iqac_cordic #(.PHASE_WIDTH(PHASE_WIDTH)) u_cordic (
		.clk, .arst_n, .start(cs_start), .phase(c_phase),
		.done(c_done), .cos_o(c_cos), .sin_o(c_sin)
	);

	iqac_divider u_div (
		.clk, .arst_n, .start(d_start),
		.dividend(div_im_q ? sum_im_q : sum_re_q), .divisor(cnt_q),
		.done(d_done), .quotient(d_quot)
	);

	// shared multiplier: one product per cycle, registered
	logic signed [39:0] ma;
	logic signed [24:0] mb;
	logic signed [PW-1:0] prod_s1, acc_q;
	logic signed [SW:0] diff;
	logic signed [SW-1:0] cur_st;
	logic signed [SW+1:0] upd;

	assign cur_st = (state_q == iqac_pkg::ST_FILT_I) ? st_im_q[k_q] : st_re_q[k_q];
	assign diff = ((state_q == iqac_pkg::ST_FILT_I) ? (SW+1)'(mi_q) : (SW+1)'(mr_q))
		- (SW+1)'(cur_st);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			iqac_pkg::ST_MIX: begin
				case (sub_q)
					2'd0: begin ma = 40'(xi_q); mb = 25'(c_q); end
					2'd1: begin ma = 40'(xq_q); mb = 25'(s_q); end
					2'd2: begin ma = 40'(xi_q); mb = 25'(s_q); end
					default: begin ma = 40'(xq_q); mb = 25'(c_q); end
				endcase
			end
			iqac_pkg::ST_FILT_R, iqac_pkg::ST_FILT_I: begin
				ma = 40'(diff); mb = 25'(signed'({1'b0, coef_q}));
			end
			iqac_pkg::ST_AUDIO: begin
				ma = sub_q[0] ? 40'(avi_q) : 40'(avr_q);
				mb = sub_q[0] ? 25'(s_q) : 25'(c_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) prod_s1 <= PW'(ma) * PW'(mb);

	// saturate helpers
	function automatic logic signed [SW-1:0] sat24(input logic signed [PW-1:0] v);
		if (v > PW'(signed'({1'b0, {(SW-1){1'b1}}}))) return {1'b0, {(SW-1){1'b1}}};
		if (v < -PW'(signed'({1'b0, {(SW-1){1'b1}}})) - 1) return {1'b1, {(SW-1){1'b0}}};
		return v[SW-1:0];
	endfunction

	logic signed [PW-1:0] rnd_aud;
	logic signed [PW-1:0] hi_s, lo_s;
	assign rnd_aud = (acc_q + (PW'(1) <<< (AUD_SH - 1))) >>> AUD_SH;
	assign hi_s = PW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
	assign lo_s = -hi_s - 1;
	assign upd = (SW+2)'(cur_st) + (SW+2)'(prod_s1 >>> iqac_pkg::COEF_W);

	logic [iqac_pkg::RATE_W-1:0] inc, rate_nx;
	assign inc = (out_rate_q < in_rate_q) ? iqac_pkg::RATE_W'(out_rate_q)
		: iqac_pkg::RATE_W'(in_rate_q);
	assign rate_nx = rate_q + inc;

	assign in_stall  = (state_q != iqac_pkg::ST_IDLE);
	assign out_valid = out_q;
	assign audio_sample = audio_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign c_phase = (state_q == iqac_pkg::ST_IDLE) ? (restart ? '0 : tune_ph_q) : tone_ph_q;

	// sequencer
	logic pipe_q;   // product in flight
	always_comb begin
		state_d  = state_q;
		cs_start = 1'b0;
		d_start  = 1'b0;
		case (state_q)
			iqac_pkg::ST_IDLE: if (accept) begin
				state_d = iqac_pkg::ST_OSC; cs_start = 1'b1;
			end
			iqac_pkg::ST_OSC: if (c_done) state_d = iqac_pkg::ST_MIX;
			iqac_pkg::ST_MIX: if (sub_q == 2'd3 && pipe_q) state_d = iqac_pkg::ST_FILT_R;
			iqac_pkg::ST_FILT_R: if (pipe_q) state_d = iqac_pkg::ST_FILT_I;
			iqac_pkg::ST_FILT_I: if (pipe_q)
				state_d = (k_q == KW'(FILTER_STAGES - 1)) ? iqac_pkg::ST_ACC
					: iqac_pkg::ST_FILT_R;
			iqac_pkg::ST_ACC: if (rate_nx >= iqac_pkg::RATE_W'(in_rate_q))
				state_d = iqac_pkg::ST_DIV;
			else state_d = iqac_pkg::ST_IDLE;
			iqac_pkg::ST_DIV: if (sub_q == 2'd0) d_start = 1'b1;
			else if (d_done && div_im_q) begin
				state_d = iqac_pkg::ST_TONE; cs_start = 1'b1;
			end
			iqac_pkg::ST_TONE: if (c_done) state_d = iqac_pkg::ST_AUDIO;
			iqac_pkg::ST_AUDIO: if (sub_q == 2'd1 && pipe_q) state_d = iqac_pkg::ST_OUT;
			iqac_pkg::ST_OUT: if (out_q && !out_stall) state_d = iqac_pkg::ST_IDLE;
			default: state_d = iqac_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= iqac_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// datapath and signal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_ph_q <= '0;
			tone_ph_q <= '0;
			for (int i = 0; i < FILTER_STAGES; i++) begin
				st_re_q[i] <= '0;
				st_im_q[i] <= '0;
			end
			sum_re_q <= '0;
			sum_im_q <= '0;
			cnt_q    <= '0;
			rate_q   <= '0;
			out_q    <= 1'b0;
			pipe_q   <= 1'b0;
			sub_q    <= '0;
			k_q      <= '0;
			div_im_q <= 1'b0;
			xi_q     <= '0;
			xq_q     <= '0;
			mr_q     <= '0;
			mi_q     <= '0;
			c_q      <= '0;
			s_q      <= '0;
			acc_q    <= '0;
			avr_q    <= '0;
			avi_q    <= '0;
			audio_q  <= '0;
		end else begin
			if (out_q && !out_stall) out_q <= 1'b0;
			case (state_q)
				iqac_pkg::ST_IDLE: if (accept) begin
					xi_q <= i_sample;
					xq_q <= q_sample;
					// restart clears signal state ahead of this word
					if (restart) begin
						tone_ph_q <= '0;
						for (int i = 0; i < FILTER_STAGES; i++) begin
							st_re_q[i] <= '0;
							st_im_q[i] <= '0;
						end
						sum_re_q <= '0;
						sum_im_q <= '0;
						cnt_q    <= '0;
						rate_q   <= '0;
						tune_ph_q <= PHASE_WIDTH'(tune_step_q);
					end else begin
						tune_ph_q <= tune_ph_q + PHASE_WIDTH'(tune_step_q);
					end
					sub_q <= '0;
					pipe_q <= 1'b0;
					k_q <= '0;
				end
				iqac_pkg::ST_OSC: if (c_done) begin
					c_q <= c_cos;
					s_q <= c_sin;
				end
				iqac_pkg::ST_MIX: begin
					// products come from the product register in the next cycle; accumulate in pairs
					pipe_q <= !pipe_q;
					if (pipe_q) begin
						case (sub_q)
							2'd0: acc_q <= prod_s1;
							2'd1: mr_q <= sat24(((acc_q - prod_s1)
								+ (PW'(1) <<< (MIX_SH - 1))) >>> MIX_SH);
							2'd2: acc_q <= prod_s1;
							default: mi_q <= sat24(((acc_q + prod_s1)
								+ (PW'(1) <<< (MIX_SH - 1))) >>> MIX_SH);
						endcase
						sub_q <= sub_q + 1'b1;
					end
				end
				iqac_pkg::ST_FILT_R: begin
					pipe_q <= !pipe_q;
					if (pipe_q) begin
						st_re_q[k_q] <= sat24(PW'(upd));
						mr_q <= sat24(PW'(upd));
					end
				end
				iqac_pkg::ST_FILT_I: begin
					pipe_q <= !pipe_q;
					if (pipe_q) begin
						st_im_q[k_q] <= sat24(PW'(upd));
						mi_q <= sat24(PW'(upd));
						k_q <= k_q + 1'b1;
					end
				end
				iqac_pkg::ST_ACC: begin
					if (cnt_q < iqac_pkg::COUNT_MAX) begin
						sum_re_q <= sum_re_q + iqac_pkg::SUM_W'(mr_q);
						sum_im_q <= sum_im_q + iqac_pkg::SUM_W'(mi_q);
						cnt_q <= cnt_q + 1'b1;
					end
					rate_q <= (rate_nx >= iqac_pkg::RATE_W'(in_rate_q))
						? rate_nx - iqac_pkg::RATE_W'(in_rate_q) : rate_nx;
					div_im_q <= 1'b0;
					sub_q <= '0;
				end
				// start each division once the sums and count have settled
				iqac_pkg::ST_DIV: if (sub_q == 2'd0) sub_q <= 2'd1;
				else if (d_done) begin
					if (div_im_q) avi_q <= d_quot;
					else begin
						avr_q <= d_quot;
						div_im_q <= 1'b1;
						sub_q <= '0;
					end
				end
				iqac_pkg::ST_TONE: if (c_done) begin
					c_q <= c_cos;
					s_q <= c_sin;
					sub_q <= '0;
					pipe_q <= 1'b0;
				end
				iqac_pkg::ST_AUDIO: begin
					pipe_q <= !pipe_q;
					if (pipe_q) begin
						if (sub_q == 2'd0) begin
							acc_q <= prod_s1;
							sub_q <= 2'd1;
						end else begin
							acc_q <= acc_q - prod_s1;
						end
					end
				end
				iqac_pkg::ST_OUT: if (!out_q) begin
					audio_q <= (rnd_aud > hi_s) ? SAMPLE_WIDTH'(hi_s)
						: (rnd_aud < lo_s) ? SAMPLE_WIDTH'(lo_s)
						: rnd_aud[SAMPLE_WIDTH-1:0];
					out_q <= 1'b1;
					tone_ph_q <= tone_ph_q + PHASE_WIDTH'(tone_step_q);
					sum_re_q <= '0;
					sum_im_q <= '0;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> design/iqac_checker.sv
// ---------------------------------------------------------------------------
// iqac_checker
// Port-level checks of the channeliser, bound to the top level.
// ---------------------------------------------------------------------------
module iqac_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] audio_sample
);
	// a stalled audio word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(audio_sample))
		else $error("audio word changed under stall");

	// an accepted word keeps the input closed next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// no new word is taken while an audio word waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while audio word waits");
endmodule

bind iq_to_audio_channelizer iqac_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_iqac_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .audio_sample
);
